// ===== rtl/tfn_pkg.sv =====
// Shared types, constants and the face corner table for the face normal generator.
`timescale 1ns / 1ps
package tfn_pkg;

    localparam int COORD_BITS_DEF       = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int FIELD_W              = 16;
    localparam int QUEUE_DEPTH          = 4;

    localparam logic [1:0] FACE_LAST = 2'd3;

    typedef struct packed {
        logic signed [FIELD_W-1:0] v0_x;
        logic signed [FIELD_W-1:0] v0_y;
        logic signed [FIELD_W-1:0] v0_z;
        logic signed [FIELD_W-1:0] v1_x;
        logic signed [FIELD_W-1:0] v1_y;
        logic signed [FIELD_W-1:0] v1_z;
        logic signed [FIELD_W-1:0] v2_x;
        logic signed [FIELD_W-1:0] v2_y;
        logic signed [FIELD_W-1:0] v2_z;
        logic signed [FIELD_W-1:0] v3_x;
        logic signed [FIELD_W-1:0] v3_y;
        logic signed [FIELD_W-1:0] v3_z;
    } t_in;

    typedef struct packed {
        logic [1:0]                face_number;
        logic signed [FIELD_W-1:0] normal_x;
        logic signed [FIELD_W-1:0] normal_y;
        logic signed [FIELD_W-1:0] normal_z;
        logic                      degenerate;
        logic                      last_face;
    } t_out;

    // Queue fill state seen by the front end
    typedef struct packed {
        logic                              empty;
        logic [$clog2(QUEUE_DEPTH+1)-1:0]  count;
    } t_qstat;

    // Corner of a face: faces (0,1,2), (0,2,3), (0,3,1), (1,3,2)
    function automatic logic [1:0] corner_of(input logic [1:0] face, input logic [1:0] slot);
        logic [5:0] row;
        row = 6'd0;
        unique case (face)
            2'd0:    row = {2'd0, 2'd1, 2'd2};
            2'd1:    row = {2'd0, 2'd2, 2'd3};
            2'd2:    row = {2'd0, 2'd3, 2'd1};
            default: row = {2'd1, 2'd3, 2'd2};
        endcase
        unique case (slot)
            2'd0:    corner_of = row[5:4];
            2'd1:    corner_of = row[3:2];
            default: corner_of = row[1:0];
        endcase
    endfunction

endpackage

// ===== rtl/tfn_queue.sv =====
// Small FIFO of classified faces between the front and back ends.
`timescale 1ns / 1ps
module tfn_queue
    import tfn_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output t_qstat           o_stat
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH+1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop)  r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_rdata      = r_mem[r_rp];
    assign o_stat.count = r_cnt;
    assign o_stat.empty = (r_cnt == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CW'(QUEUE_DEPTH)) |-> !i_push || i_pop)
        else $error("face queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("face queue underflow");
endmodule

// ===== rtl/tfn_front.sv =====
// Front end: takes tetrahedra, walks the four faces and forms cross products and squares.
`timescale 1ns / 1ps
module tfn_front
    import tfn_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int EW         = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in           i_in_data,
    input  t_qstat        i_qstat,
    output logic          o_push,
    output logic [EW-1:0] o_entry
);
    localparam int D  = COORD_BITS + 1;
    localparam int P  = 2 * D;
    localparam int C  = P + 1;
    localparam int SW = 2 * C + 2;
    localparam int CW = $clog2(QUEUE_DEPTH+1);

    t_in        r_item;
    logic       r_have;
    logic [1:0] r_face;

    logic signed [COORD_BITS-1:0] w_co  [12];
    logic signed [D-1:0]          n_ab [3], n_bc [3];
    logic [1:0]                   w_a, w_b, w_c;
    logic                         w_issue;
    logic [CW-1:0]                w_inflight;

    // Pipeline registers
    logic                r_v0, r_v1, r_v2, r_v3;
    logic [1:0]          r_f0, r_f1, r_f2, r_f3;
    logic signed [D-1:0] r_ab [3], r_bc [3];
    logic signed [P-1:0] r_pr [6];
    logic signed [C-1:0] r_cr [3];
    logic [2*C-1:0]      r_sq [3];
    logic [2:0]          r_sg;
    logic [SW-1:0]       w_sum;

    logic [FIELD_W-1:0] w_held [12];
    assign w_held = '{r_item.v0_x, r_item.v0_y, r_item.v0_z,
                      r_item.v1_x, r_item.v1_y, r_item.v1_z,
                      r_item.v2_x, r_item.v2_y, r_item.v2_z,
                      r_item.v3_x, r_item.v3_y, r_item.v3_z};

    // Narrow or widen each held coordinate to COORD_BITS
    for (genvar j = 0; j < 12; j++) begin : g_co
        if (COORD_BITS <= FIELD_W) begin : g_narrow
            assign w_co[j] = w_held[j][COORD_BITS-1:0];
        end else begin : g_wide
            assign w_co[j] = {{(COORD_BITS-FIELD_W){1'b0}}, w_held[j]};
        end
    end

    // Issue a face only when the queue is sure to have room for it
    assign w_inflight = CW'(r_v0) + CW'(r_v1) + CW'(r_v2) + CW'(r_v3);
    assign w_issue    = r_have && ((i_qstat.count + w_inflight) < CW'(QUEUE_DEPTH));
    assign o_in_ready = !r_have || (w_issue && (r_face == FACE_LAST));

    // Edge vectors of the current face
    always_comb begin
        w_a = corner_of(r_face, 2'd0);
        w_b = corner_of(r_face, 2'd1);
        w_c = corner_of(r_face, 2'd2);
        for (int i = 0; i < 3; i++) begin
            n_ab[i] = D'(w_co[4'(w_b*3+i)]) - D'(w_co[4'(w_a*3+i)]);
            n_bc[i] = D'(w_co[4'(w_c*3+i)]) - D'(w_co[4'(w_b*3+i)]);
        end
    end

    // Hold the tetrahedron and step through its faces
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_face <= '0;
        end else if (i_in_valid && o_in_ready) begin
            r_have <= 1'b1;
            r_face <= '0;
        end else if (w_issue) begin
            r_face <= r_face + 2'd1;
            if (r_face == FACE_LAST) r_have <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_item <= i_in_data;
    end

    // Valid bits of the arithmetic pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= w_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Edges, products, cross product, squares
    always_ff @(posedge i_clk) begin
        r_f0 <= r_face;
        r_f1 <= r_f0;
        r_f2 <= r_f1;
        r_f3 <= r_f2;
        for (int i = 0; i < 3; i++) begin
            r_ab[i] <= n_ab[i];
            r_bc[i] <= n_bc[i];
        end
        r_pr[0] <= r_ab[1] * r_bc[2];
        r_pr[1] <= r_ab[2] * r_bc[1];
        r_pr[2] <= r_ab[2] * r_bc[0];
        r_pr[3] <= r_ab[0] * r_bc[2];
        r_pr[4] <= r_ab[0] * r_bc[1];
        r_pr[5] <= r_ab[1] * r_bc[0];
        for (int i = 0; i < 3; i++) begin
            r_cr[i] <= C'(r_pr[2*i]) - C'(r_pr[2*i+1]);
            r_sq[i] <= (2*C)'(r_cr[i] * r_cr[i]);
            r_sg[i] <= r_cr[i][C-1];
        end
    end

    assign w_sum   = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    assign o_push  = r_v3;
    assign o_entry = {r_f3, r_sg, r_sq[0], r_sq[1], r_sq[2], w_sum};

    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_qstat.count + w_inflight) <= CW'(QUEUE_DEPTH))
        else $error("faces in flight exceed queue room");
endmodule

// ===== rtl/tfn_back.sv =====
// Back end: scales each cross product to unit length, one result bit per cycle per lane.
`timescale 1ns / 1ps
module tfn_back
    import tfn_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
    parameter int EW               = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_winding_ccw,
    input  logic [EW-1:0] i_entry,
    input  t_qstat        i_qstat,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_out          o_out_data
);
    localparam int F  = NORMAL_FRAC_BITS;
    localparam int C  = 2 * (COORD_BITS + 1) + 1;
    localparam int SW = 2 * C + 2;
    localparam int WP = 2 * C + 2 * F + 7;
    localparam int KW = $clog2(F + 1);
    localparam int NW = (F + 2 > FIELD_W) ? F + 2 : FIELD_W;

    logic [1:0]     e_face;
    logic [2:0]     e_sg;
    logic [2*C-1:0] e_sq [3];
    logic [SW-1:0]  e_sum;
    assign {e_face, e_sg, e_sq[0], e_sq[1], e_sq[2], e_sum} = i_entry;

    logic                 r_busy, r_done;
    logic [KW-1:0]        r_k;
    logic [1:0]           r_face;
    logic [2:0]           r_sg;
    logic                 r_dg;
    logic signed [WP-1:0] r_ss;
    logic signed [WP-1:0] r_p [3], r_qs [3], r_r [3];
    logic [F:0]           r_t [3];
    logic signed [WP-1:0] w_try [3];
    logic signed [WP-1:0] w_s;
    logic                 w_emit;
    logic signed [NW-1:0] w_n [3];
    logic                 r_ov;
    t_out                 r_od;

    assign w_s    = WP'(e_sum);
    assign o_pop  = !r_busy && !i_qstat.empty;
    assign w_emit = r_done && (!r_ov || i_out_ready);

    // Trial value (2t-1)^2 * S for each lane with the current bit set
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_try[i] = r_p[i] + r_qs[i] + r_ss;
        end
    end

    // Signed, fallback and winding applied to the finished magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_n[i] = NW'(r_t[i]);
            if (r_sg[i]) w_n[i] = -w_n[i];
            if (r_dg) w_n[i] = (i == 0) ? (NW'(1) <<< F) : '0;
            if (!i_winding_ccw) w_n[i] = -w_n[i];
        end
    end

    // Control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && !r_done) begin
            if (r_k == '0) r_done <= 1'b1;
        end else if (w_emit) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end
    end

    // Load a face, then decide one bit of each component a cycle
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_k    <= KW'(F);
            r_face <= e_face;
            r_sg   <= e_sg;
            r_dg   <= (e_sum == '0);
            r_ss   <= w_s <<< (2 * F + 2);
            for (int i = 0; i < 3; i++) begin
                r_p[i]  <= w_s;
                r_qs[i] <= -(w_s <<< (F + 2));
                r_r[i]  <= WP'(e_sq[i]) <<< (2 * F + 2);
                r_t[i]  <= '0;
            end
        end else if (r_busy && !r_done) begin
            r_k  <= r_k - KW'(1);
            r_ss <= r_ss >>> 2;
            for (int i = 0; i < 3; i++) begin
                if (w_try[i] <= r_r[i]) begin
                    r_p[i]      <= w_try[i];
                    r_qs[i]     <= (r_qs[i] + (r_ss <<< 1)) >>> 1;
                    r_t[i][r_k] <= 1'b1;
                end else begin
                    r_qs[i] <= r_qs[i] >>> 1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_od.face_number <= r_face;
            r_od.normal_x    <= w_n[0][FIELD_W-1:0];
            r_od.normal_y    <= w_n[1][FIELD_W-1:0];
            r_od.normal_z    <= w_n[2][FIELD_W-1:0];
            r_od.degenerate  <= r_dg;
            r_od.last_face   <= (r_face == FACE_LAST);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_busy)
        else $error("finished flag without a face in work");
    a_load_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_k == KW'(F)) && r_busy && !r_done)
        else $error("bit counter not restarted on load");
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.degenerate) |->
        (o_out_data.normal_y == '0) && (o_out_data.normal_z == '0))
        else $error("fallback normal has off-axis parts");
endmodule

// ===== rtl/tetra_face_normal_generator_core.sv =====
// Top level of the tetrahedron face normal generator.
`timescale 1ns / 1ps
// Takes one tetrahedron (four Q8.8 corners) per input beat and returns four output beats,
// one unit face normal each in Q1.14, faces (0,1,2), (0,2,3), (0,3,1), (1,3,2) in order.
// The front end forms one face's cross product a cycle while the queue has room, through a
// four-stage pipeline, and parks it in a four-entry queue; the back end scales the three
// components in parallel, settling one result bit per cycle, and takes the next face only
// once the last is in the output register. That per-face normalising loop sets the rate.
// A new tetrahedron is taken while earlier faces are still being scaled. A zero cross
// product gives (1,0,0) with the degenerate flag; clearing winding_ccw negates every
// normal.
module tetra_face_normal_generator_core
    import tfn_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);
    localparam int C  = 2 * (COORD_BITS + 1) + 1;
    localparam int EW = 2 + 3 + 3 * (2 * C) + (2 * C + 2);

    logic          r_winding_ccw;
    logic          w_push, w_pop;
    logic [EW-1:0] w_wentry, w_rentry;
    t_qstat        w_qstat;

    // Winding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_winding_ccw <= 1'b1;
        end else if (i_cfg_we) begin
            r_winding_ccw <= i_cfg_wdata;
        end
    end

    tfn_front #(.COORD_BITS(COORD_BITS), .EW(EW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_entry    (w_wentry)
    );

    tfn_queue #(.WIDTH(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wentry),
        .i_pop   (w_pop),
        .o_rdata (w_rentry),
        .o_stat  (w_qstat)
    );

    tfn_back #(
        .COORD_BITS       (COORD_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
        .EW               (EW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_winding_ccw (r_winding_ccw),
        .i_entry       (w_rentry),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );
endmodule

// ===== test/tb_tetra_face_normal_generator_core.sv =====
// Self-checking testbench for the tetrahedron face normal generator.
`timescale 1ns / 1ps
module tb_tetra_face_normal_generator_core;
    import tfn_pkg::*;

    localparam int FRAC      = NORMAL_FRAC_BITS_DEF;
    localparam int SETTLE    = 120;     // extra idle cycles after the last expected normal
    localparam int FACES     = 4;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    t_in  tetra_q[$];       // tetrahedra waiting to be driven
    t_out normal_q[$];      // face normals still due from the block
    logic winding_ccw;
    int   burst_left;
    int   gap_left;
    int   stall_mode;
    int   mode_cycles;
    int   n_sent;
    int   n_checked;
    int   n_degen;
    int   n_errors;

    tetra_face_normal_generator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Round |c| * 2^FRAC / sqrt(sum_sq) to nearest, ties away from zero, by squared compare
    function automatic int unsigned scale_mag(input longint c, input logic [159:0] sum_sq);
        logic [159:0] mag_sq;
        logic [159:0] lhs;
        logic [159:0] odd;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        mag_sq = (c < 0) ? 160'(-c) : 160'(c);
        mag_sq = (mag_sq * mag_sq) << (2 + 2 * FRAC);
        lo = 0;
        hi = 1 << FRAC;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            odd = 160'(2 * mid - 1);
            lhs = odd * odd * sum_sq;
            if (lhs <= mag_sq) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // Work out the four face normals of one tetrahedron and queue them
    task automatic predict_normals(input t_in t);
        longint      p[4][3];
        longint      ab[3];
        longint      bc[3];
        longint      cr[3];
        logic [15:0] res[3];
        logic [159:0] sum_sq;
        int          corner[4][3];
        int          a, b, c;
        t_out        o;
        corner = '{'{0, 1, 2}, '{0, 2, 3}, '{0, 3, 1}, '{1, 3, 2}};
        p[0] = '{longint'(t.v0_x), longint'(t.v0_y), longint'(t.v0_z)};
        p[1] = '{longint'(t.v1_x), longint'(t.v1_y), longint'(t.v1_z)};
        p[2] = '{longint'(t.v2_x), longint'(t.v2_y), longint'(t.v2_z)};
        p[3] = '{longint'(t.v3_x), longint'(t.v3_y), longint'(t.v3_z)};
        for (int f = 0; f < FACES; f++) begin
            a = corner[f][0];
            b = corner[f][1];
            c = corner[f][2];
            for (int i = 0; i < 3; i++) begin
                ab[i] = p[b][i] - p[a][i];
                bc[i] = p[c][i] - p[b][i];
            end
            cr[0] = ab[1] * bc[2] - ab[2] * bc[1];
            cr[1] = ab[2] * bc[0] - ab[0] * bc[2];
            cr[2] = ab[0] * bc[1] - ab[1] * bc[0];
            o = '0;
            o.face_number = 2'(f);
            o.last_face   = (2'(f) == FACE_LAST);
            if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
                o.degenerate = 1'b1;
                res[0] = 16'(1 << FRAC);
                res[1] = '0;
                res[2] = '0;
            end else begin
                sum_sq = '0;
                for (int i = 0; i < 3; i++)
                    sum_sq += ((cr[i] < 0) ? 160'(-cr[i]) : 160'(cr[i]))
                            * ((cr[i] < 0) ? 160'(-cr[i]) : 160'(cr[i]));
                for (int i = 0; i < 3; i++) begin
                    res[i] = 16'(scale_mag(cr[i], sum_sq));
                    if (cr[i] < 0) res[i] = -res[i];
                end
            end
            // Clockwise winding flips every normal, fallback axis too
            for (int i = 0; i < 3; i++)
                if (!winding_ccw) res[i] = -res[i];
            o.normal_x = res[0];
            o.normal_y = res[1];
            o.normal_z = res[2];
            normal_q = {normal_q, o};
        end
    endtask

    // Driver: bursts of beats with random gaps between them
    always @(posedge i_clk) begin
        logic fire;
        logic nxt_valid;
        t_in  nxt_data;
        fire      = i_in_valid && o_in_ready;
        nxt_valid = i_in_valid;
        nxt_data  = i_in_data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (fire) begin
                predict_normals(i_in_data);
                n_sent++;
            end
            if (!i_in_valid || fire) begin
                nxt_valid = 1'b0;
                if (burst_left == 0 && gap_left > 0) begin
                    gap_left--;
                end else if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
                if (burst_left > 0 && tetra_q.size() > 0) begin
                    nxt_valid = 1'b1;
                    nxt_data  = tetra_q.pop_front();
                    burst_left--;
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data  <= nxt_data;
    end

    // Monitor: check each accepted beat against the oldest expected normal
    always @(posedge i_clk) begin
        t_out exp_n;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (normal_q.size() == 0) begin
                $error("unexpected beat: face %0d", o_out_data.face_number);
                n_errors++;
            end else begin
                exp_n = normal_q.pop_front();
                n_checked++;
                if (exp_n.degenerate) n_degen++;
                if (o_out_data.face_number !== exp_n.face_number) begin
                    $error("face_number exp %0d got %0d", exp_n.face_number,
                           o_out_data.face_number);
                    n_errors++;
                end
                if (o_out_data.normal_x !== exp_n.normal_x) begin
                    $error("normal_x exp %0d got %0d", exp_n.normal_x, o_out_data.normal_x);
                    n_errors++;
                end
                if (o_out_data.normal_y !== exp_n.normal_y) begin
                    $error("normal_y exp %0d got %0d", exp_n.normal_y, o_out_data.normal_y);
                    n_errors++;
                end
                if (o_out_data.normal_z !== exp_n.normal_z) begin
                    $error("normal_z exp %0d got %0d", exp_n.normal_z, o_out_data.normal_z);
                    n_errors++;
                end
                if (o_out_data.degenerate !== exp_n.degenerate) begin
                    $error("degenerate exp %0b got %0b", exp_n.degenerate,
                           o_out_data.degenerate);
                    n_errors++;
                end
                if (o_out_data.last_face !== exp_n.last_face) begin
                    $error("last_face exp %0b got %0b", exp_n.last_face, o_out_data.last_face);
                    n_errors++;
                end
            end
        end
    end

    // Receiver stall pattern: switch between always ready, patchy and mostly stalled
    always @(posedge i_clk) begin
        if (mode_cycles == 0) begin
            stall_mode  = $urandom_range(0, 2);
            mode_cycles = $urandom_range(20, 150);
        end else begin
            mode_cycles--;
        end
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 1) == 1);
            default: i_out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    function automatic void a_copy(inout logic [15:0] v[12], input int dst, input int src);
        for (int i = 0; i < 3; i++) v[dst*3+i] = v[src*3+i];
    endfunction

    function automatic t_in make_tetra(input int kind);
        t_in         t;
        logic [15:0] v[12];
        int          lim;
        for (int i = 0; i < 12; i++) v[i] = 16'($urandom);
        case (kind)
            // small coordinates around the origin
            1: begin
                lim = $urandom_range(1, 600);
                for (int i = 0; i < 12; i++) v[i] = 16'($urandom_range(0, 2 * lim) - lim);
            end
            // one corner copied onto a random corner: when the two differ, faces collapse
            2: begin
                a_copy(v, $urandom_range(0, 3), $urandom_range(0, 3));
            end
            // all corners on one line through corner 0
            3: begin
                for (int k = 1; k < 4; k++) begin
                    lim = $urandom_range(0, 6) - 3;
                    for (int i = 0; i < 3; i++) v[k*3+i] = v[i] + 16'(lim * 5);
                end
            end
            // full-scale extremes
            4: begin
                for (int i = 0; i < 12; i++)
                    v[i] = ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
            end
            default: ;
        endcase
        t = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
        return t;
    endfunction

    // Append one tetrahedron to the pending list
    task automatic enqueue_tetra(input t_in t);
        tetra_q = {tetra_q, t};
    endtask

    task automatic wait_idle();
        while (tetra_q.size() != 0 || i_in_valid || normal_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_winding(input logic ccw);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ccw;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        winding_ccw  = ccw;
    endtask

    task automatic queue_random(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 9);
            enqueue_tetra(make_tetra(r < 4 ? 0 : r < 6 ? 1 : r < 8 ? 2 : r < 9 ? 3 : 4));
        end
    endtask

    // Stimulus: directed corners first, then random phases under both windings
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        winding_ccw = 1'b1;
        burst_left  = 0;
        gap_left    = 0;
        stall_mode  = 0;
        mode_cycles = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_degen     = 0;
        n_errors    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all corners equal: every face degenerate
        enqueue_tetra('0);
        enqueue_tetra({12{16'h7fff}});
        enqueue_tetra({12{16'h8000}});
        // unit tetrahedron
        enqueue_tetra({48'h0, 16'h0100, 32'h0, 16'h0, 16'h0100, 16'h0, 32'h0, 16'h0100});
        // opposite extremes
        enqueue_tetra({{3{16'h8000}}, 16'h7fff, 32'h8000_8000, 16'h8000, 16'h7fff,
                       16'h8000, 32'h8000_8000, 16'h7fff});
        enqueue_tetra({{3{16'h7fff}}, 16'h8000, 32'h7fff_7fff, 16'h7fff, 16'h8000,
                       16'h7fff, 32'h7fff_7fff, 16'h8000});
        enqueue_tetra({12{16'h5555}} ^ {6{32'hffff_0000}});
        enqueue_tetra({12{16'haaaa}} ^ {6{16'hffff, 16'h0000}});
        // axis-aligned faces giving components of 0 and exactly one unit
        enqueue_tetra({48'h0, 16'h0001, 32'h0, 16'h0, 16'h0001, 16'h0, 32'h0, 16'hffff});
        for (int k = 0; k < 5; k++) enqueue_tetra(make_tetra(2));
        for (int k = 0; k < 3; k++) enqueue_tetra(make_tetra(3));
        for (int k = 0; k < 4; k++) enqueue_tetra(make_tetra(4));
        wait_idle();

        write_winding(1'b0);
        enqueue_tetra('0);
        enqueue_tetra({48'h0, 16'h0100, 32'h0, 16'h0, 16'h0100, 16'h0, 32'h0, 16'h0100});
        queue_random(55);
        wait_idle();

        write_winding(1'b1);
        queue_random(60);
        wait_idle();

        write_winding(1'b0);
        queue_random(35);
        wait_idle();

        $display("Checked %0d normals from %0d tetrahedra (%0d degenerate), both windings.",
                 n_checked, n_sent, n_degen);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3ms;
        $display("Timeout with %0d normals outstanding.", normal_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
